/* hw/rtl/rbsi_pkg.sv */
// rbsi_pkg: shared constants for the ray/box slab intersection block.
// Fixed t format (signed, 12 fraction bits, 49 bits) and face codes.
// No dependencies.
`timescale 1ns / 1ps

package rbsi_pkg;

  localparam int T_W    = 49;
  localparam int FACE_W = 3;

  localparam logic signed [T_W-1:0] T_SAT = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [T_W-1:0] T_INF = 49'sh0_8000_0000_0000;

  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd0;
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd1;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd2;
  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd3;
  localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd4;
  localparam logic [FACE_W-1:0] FACE_BACK   = 3'd5;
  localparam logic [FACE_W-1:0] FACE_NONE   = 3'd6;

endpackage

/* hw/rtl/ray_box_slab_intersect.sv */
// ray_box_slab_intersect: ray versus axis-aligned box, slab method.
// Pipeline: an input stage, a row of divider cells, one quotient bit per cell,
// then the fold stages that form t values, fold x, y and z, and pick the face.
// Throughput: one transfer per cycle; the whole pipeline holds while a
// result waits at the output. Reset (rst_n, synchronous) clears valid bits.
// Uses rbsi_pkg, rbsi_div_cell, rbsi_fold.
`timescale 1ns / 1ps

module ray_box_slab_intersect
  import rbsi_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int DIR_WIDTH   = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // box_min_x,y,z, box_max_x,y,z, origin_x,y,z (COORD_WIDTH each),
  // dir_x,y,z (DIR_WIDTH each), zero fill
  input  logic [((9*COORD_WIDTH+3*DIR_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // hit[0], entry_face[3:1], zero fill
  output logic [7:0] out_tdata
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = DIR_WIDTH;
  localparam int DF = DW - 2;
  localparam int QW = CW + DF;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // input stage
  logic               p_valid_r;
  logic [5:0][DW-1:0] p_rem_r;
  logic [5:0][QW-1:0] p_nq_r, p_nq_nxt;
  logic [5:0][DW-1:0] p_d_r, p_d_nxt;
  logic [5:0]         p_neg_r, p_neg_nxt, p_zdir_r, p_zdir_nxt, p_zpos_r, p_zpos_nxt;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      logic signed [CW-1:0] bnd, org;
      logic signed [DW-1:0] dir;
      logic signed [CW:0]   diff;
      logic [CW:0]          mag;
      bnd  = in_tdata[((i%2)*3 + i/2)*CW +: CW];
      org  = in_tdata[(6 + i/2)*CW +: CW];
      dir  = in_tdata[9*CW + (i/2)*DW +: DW];
      diff = (CW+1)'(bnd) - (CW+1)'(org);
      mag  = diff[CW] ? -diff : diff;
      p_nq_nxt[i]   = {mag[CW-1:0], {DF{1'b0}}};
      p_d_nxt[i]    = dir[DW-1] ? -dir : dir;
      p_neg_nxt[i]  = diff[CW] ^ dir[DW-1];
      p_zdir_nxt[i] = (dir == '0);
      p_zpos_nxt[i] = (!diff[CW] && diff != '0) || (diff == '0 && (i % 2 == 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_rem_r  <= '0;
      p_nq_r   <= p_nq_nxt;
      p_d_r    <= p_d_nxt;
      p_neg_r  <= p_neg_nxt;
      p_zdir_r <= p_zdir_nxt;
      p_zpos_r <= p_zpos_nxt;
    end
  end

  // divider cell chain
  logic               c_valid [QW+1];
  logic [5:0][DW-1:0] c_rem   [QW+1];
  logic [5:0][QW-1:0] c_nq    [QW+1];
  logic [5:0][DW-1:0] c_d     [QW+1];
  logic [5:0]         c_neg   [QW+1];
  logic [5:0]         c_zdir  [QW+1];
  logic [5:0]         c_zpos  [QW+1];

  assign c_valid[0] = p_valid_r;
  assign c_rem[0]   = p_rem_r;
  assign c_nq[0]    = p_nq_r;
  assign c_d[0]     = p_d_r;
  assign c_neg[0]   = p_neg_r;
  assign c_zdir[0]  = p_zdir_r;
  assign c_zpos[0]  = p_zpos_r;

  for (genvar g = 0; g < QW; g++) begin : g_cell
    rbsi_div_cell #(.DW(DW), .QW(QW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (c_valid[g]),
      .rem_i   (c_rem[g]),
      .nq_i    (c_nq[g]),
      .d_i     (c_d[g]),
      .neg_i   (c_neg[g]),
      .zdir_i  (c_zdir[g]),
      .zpos_i  (c_zpos[g]),
      .valid_o (c_valid[g+1]),
      .rem_o   (c_rem[g+1]),
      .nq_o    (c_nq[g+1]),
      .d_o     (c_d[g+1]),
      .neg_o   (c_neg[g+1]),
      .zdir_o  (c_zdir[g+1]),
      .zpos_o  (c_zpos[g+1])
    );
  end

  logic              hit;
  logic [FACE_W-1:0] face;

  rbsi_fold #(.QW(QW)) u_fold (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (c_valid[QW]),
    .q_i     (c_nq[QW]),
    .neg_i   (c_neg[QW]),
    .zdir_i  (c_zdir[QW]),
    .zpos_i  (c_zpos[QW]),
    .valid_o (out_tvalid),
    .hit_o   (hit),
    .face_o  (face)
  );

  assign out_tdata = {4'b0000, face, hit};

endmodule

/* hw/rtl/rbsi_div_cell.sv */
// rbsi_div_cell: one restoring-division step for all six slab lanes.
// Produces one quotient bit per lane and hands the lane state onward.
// No package dependencies.
`timescale 1ns / 1ps

module rbsi_div_cell #(
  parameter int DW = 16,
  parameter int QW = 46
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic [5:0][DW-1:0]   rem_i,
  input  logic [5:0][QW-1:0]   nq_i,
  input  logic [5:0][DW-1:0]   d_i,
  input  logic [5:0]           neg_i,
  input  logic [5:0]           zdir_i,
  input  logic [5:0]           zpos_i,
  output logic                 valid_o,
  output logic [5:0][DW-1:0]   rem_o,
  output logic [5:0][QW-1:0]   nq_o,
  output logic [5:0][DW-1:0]   d_o,
  output logic [5:0]           neg_o,
  output logic [5:0]           zdir_o,
  output logic [5:0]           zpos_o
);

  logic              valid_r;
  logic [5:0][DW-1:0] rem_r, rem_nxt;
  logic [5:0][QW-1:0] nq_r, nq_nxt;
  logic [5:0][DW-1:0] d_r;
  logic [5:0]         neg_r, zdir_r, zpos_r;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      logic [DW:0] rp;
      logic        ge;
      rp = {rem_i[i], nq_i[i][QW-1]};
      ge = (rp >= {1'b0, d_i[i]});
      rem_nxt[i] = ge ? DW'(rp - {1'b0, d_i[i]}) : rp[DW-1:0];
      nq_nxt[i]  = {nq_i[i][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      nq_r   <= nq_nxt;
      d_r    <= d_i;
      neg_r  <= neg_i;
      zdir_r <= zdir_i;
      zpos_r <= zpos_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign nq_o    = nq_r;
  assign d_o     = d_r;
  assign neg_o   = neg_r;
  assign zdir_o  = zdir_r;
  assign zpos_o  = zpos_r;

endmodule

/* hw/rtl/rbsi_fold.sv */
// rbsi_fold: turns quotients into slab t values, folds the interval
// over x, y, z and picks hit and entry face. Uses rbsi_pkg.
`timescale 1ns / 1ps

module rbsi_fold
  import rbsi_pkg::*;
#(
  parameter int QW = 46
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  logic [5:0][QW-1:0] q_i,
  input  logic [5:0]         neg_i,
  input  logic [5:0]         zdir_i,
  input  logic [5:0]         zpos_i,
  output logic               valid_o,
  output logic               hit_o,
  output logic [FACE_W-1:0]  face_o
);

  localparam int QX = (QW > T_W) ? QW : T_W;

  function automatic logic signed [T_W-1:0] smin(logic signed [T_W-1:0] a,
                                                 logic signed [T_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [T_W-1:0] smax(logic signed [T_W-1:0] a,
                                                 logic signed [T_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic [2:0] valid_r;
  logic signed [T_W-1:0] ta_r [6];
  logic signed [T_W-1:0] tb_r [6];
  logic signed [T_W-1:0] tc_r [6];
  logic signed [T_W-1:0] ta_nxt [6];
  logic signed [T_W-1:0] tminb_r, tmaxb_r, tminb_nxt, tmaxb_nxt;
  logic signed [T_W-1:0] tminc_r, tmaxc_r, tminc_nxt, tmaxc_nxt;
  logic                  hit_r, hit_nxt;
  logic [FACE_W-1:0]     face_r, face_nxt;
  logic                  valid_out_r;

  // saturate and sign each quotient; zero-direction lanes get +/-T_INF
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      logic [QX-1:0]         qx;
      logic signed [T_W-1:0] qm;
      qx = QX'(q_i[i]);
      qm = (qx > QX'(T_SAT)) ? T_SAT : T_W'(qx);
      if (zdir_i[i]) begin
        ta_nxt[i] = zpos_i[i] ? T_INF : -T_INF;
      end else begin
        ta_nxt[i] = neg_i[i] ? -qm : qm;
      end
    end
  end

  // x and y folds
  always_comb begin
    logic signed [T_W-1:0] mn, mx, lo, hi;
    mn = smin(ta_r[0], ta_r[1]);
    mx = smax(ta_r[0], ta_r[1]);
    lo = smin(ta_r[2], ta_r[3]);
    hi = smax(ta_r[2], ta_r[3]);
    tminb_nxt = smax(mn, smin(lo, mx));
    tmaxb_nxt = smin(mx, smax(hi, tminb_nxt));
  end

  // z fold
  always_comb begin
    logic signed [T_W-1:0] lo, hi;
    lo = smin(tb_r[4], tb_r[5]);
    hi = smax(tb_r[4], tb_r[5]);
    tminc_nxt = smax(tminb_r, smin(lo, tmaxb_r));
    tmaxc_nxt = smin(tmaxb_r, smax(hi, tminc_nxt));
  end

  always_comb begin
    hit_nxt = (tmaxc_r > smax(tminc_r, '0));
    if (tc_r[0] == tminc_r) begin
      face_nxt = FACE_LEFT;
    end else if (tc_r[1] == tminc_r) begin
      face_nxt = FACE_RIGHT;
    end else if (tc_r[2] == tminc_r) begin
      face_nxt = FACE_BOTTOM;
    end else if (tc_r[3] == tminc_r) begin
      face_nxt = FACE_TOP;
    end else if (tc_r[4] == tminc_r) begin
      face_nxt = FACE_FRONT;
    end else if (tc_r[5] == tminc_r) begin
      face_nxt = FACE_BACK;
    end else begin
      face_nxt = FACE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      valid_out_r <= 1'b0;
    end else if (en) begin
      valid_r     <= {valid_r[1:0], valid_i};
      valid_out_r <= valid_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ta_r    <= ta_nxt;
      tb_r    <= ta_r;
      tc_r    <= tb_r;
      tminb_r <= tminb_nxt;
      tmaxb_r <= tmaxb_nxt;
      tminc_r <= tminc_nxt;
      tmaxc_r <= tmaxc_nxt;
      hit_r   <= hit_nxt;
      face_r  <= face_nxt;
    end
  end

  assign valid_o = valid_out_r;
  assign hit_o   = hit_r;
  assign face_o  = face_r;

endmodule

/* verif/ray_box_slab_intersect_tb.sv */
// Self-checking bench for ray_box_slab_intersect: drives box/ray transfers,
// predicts hit and entry face per transfer, and compares results in order.
// Depends on rbsi_pkg and the ray_box_slab_intersect RTL.
`timescale 1ns / 1ps

module ray_box_slab_intersect_tb;
  import rbsi_pkg::*;

  localparam int CW = 32;
  localparam int DW = 16;
  localparam int DFRAC = DW - 2;
  localparam int IN_W = ((9*CW + 3*DW + 7)/8)*8;
  localparam int N_RAND = 1830;
  localparam int LATENCY = CW + DW + 3;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic              hit;
  } hit_rec_t;

  typedef struct {
    logic signed [CW-1:0] bmin[3];
    logic signed [CW-1:0] bmax[3];
    logic signed [CW-1:0] org[3];
    logic signed [DW-1:0] dir[3];
  } ray_box_t;

  typedef struct {
    ray_box_t rb;
    bit       known;
    hit_rec_t res;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [7:0] out_tdata;

  hit_rec_t hits_pending[$];
  int  mismatches = 0;
  longint cycles = 0;
  int  n_hits = 0;
  int  n_results = 0;
  row_t dir_rows[$];

  always #6 clk = ~clk;

  ray_box_slab_intersect dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic logic signed [T_W-1:0] slab_param(
      logic signed [CW-1:0] bound, logic signed [CW-1:0] origin,
      logic signed [DW-1:0] dir, bit upper);
    longint diff;
    longint unsigned mag, d, qi, q;
    diff = longint'(bound) - longint'(origin);
    if (dir == 0) begin
      if (diff > 0) return T_INF;
      if (diff < 0) return -T_INF;
      return upper ? T_INF : -T_INF;
    end
    mag = diff < 0 ? -diff : diff;
    d = dir < 0 ? -longint'(dir) : longint'(dir);
    qi = mag / d;
    if (qi >= (64'd1 << (47 - DFRAC))) q = T_SAT;
    else begin
      q = (qi << DFRAC) + (((mag % d) << DFRAC) / d);
      if (q > T_SAT) q = T_SAT;
    end
    return ((diff < 0) != (dir < 0)) ? -$signed(q[T_W-1:0]) : $signed(q[T_W-1:0]);
  endfunction

  function automatic hit_rec_t box_hit(ray_box_t rb);
    logic signed [T_W-1:0] t[6];
    logic signed [T_W-1:0] tmin, tmax, lo, hi, z;
    hit_rec_t r;
    z = '0;
    for (int a = 0; a < 3; a++) begin
      t[2*a]   = slab_param(rb.bmin[a], rb.org[a], rb.dir[a], 0);
      t[2*a+1] = slab_param(rb.bmax[a], rb.org[a], rb.dir[a], 1);
    end
    tmin = t[0] < t[1] ? t[0] : t[1];
    tmax = t[0] > t[1] ? t[0] : t[1];
    for (int a = 1; a < 3; a++) begin
      lo = t[2*a] < t[2*a+1] ? t[2*a] : t[2*a+1];
      hi = t[2*a] > t[2*a+1] ? t[2*a] : t[2*a+1];
      if (lo > tmax) lo = tmax;
      if (lo > tmin) tmin = lo;
      if (hi < tmin) hi = tmin;
      if (hi < tmax) tmax = hi;
    end
    r.face = FACE_NONE;
    for (int k = 5; k >= 0; k--)
      if (t[k] == tmin) r.face = k[FACE_W-1:0];
    r.hit = tmax > ((tmin > z) ? tmin : z);
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_ray_box(ray_box_t rb);
    logic [IN_W-1:0] v;
    v = '0;
    for (int a = 0; a < 3; a++) begin
      v[a*CW +: CW] = rb.bmin[a];
      v[(3+a)*CW +: CW] = rb.bmax[a];
      v[(6+a)*CW +: CW] = rb.org[a];
      v[9*CW + a*DW +: DW] = rb.dir[a];
    end
    return v;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 200000)) - 100000;
    endcase
  endfunction

  function automatic logic signed [DW-1:0] rand_dir();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return DW'($urandom);
      2: return $urandom_range(0, 1) ? 16'sh4000 : -16'sh4000;
      3: return DW'($signed($urandom_range(0, 8)) - 4);
      default: return DW'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // Mostly rays aimed at the box interior so hits and every face show up.
  function automatic ray_box_t rand_ray_box();
    ray_box_t rb;
    logic signed [CW-1:0] tgt;
    int shape;
    shape = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      rb.dir[a] = rand_dir();
      if (shape < 7) begin
        rb.bmin[a] = $signed($urandom_range(0, 80000)) - 40000;
        rb.bmax[a] = rb.bmin[a] + $signed($urandom_range(0, 40000));
        tgt = rb.bmin[a] + $signed($urandom_range(0, 40000));
        rb.org[a] = CW'(tgt - ((longint'(rb.dir[a]) * $urandom_range(0, 64)) >>> 2));
        if (shape == 6) rb.org[a] = rb.bmin[a];
      end else begin
        rb.bmin[a] = rand_coord();
        rb.bmax[a] = rand_coord();
        rb.org[a] = rand_coord();
      end
    end
    return rb;
  endfunction

  function automatic ray_box_t mk(int b0, int b1, int o, int dx, int dy, int dz);
    ray_box_t rb;
    for (int a = 0; a < 3; a++) begin
      rb.bmin[a] = b0;
      rb.bmax[a] = b1;
      rb.org[a] = o;
    end
    rb.dir[0] = DW'(dx);
    rb.dir[1] = DW'(dy);
    rb.dir[2] = DW'(dz);
    return rb;
  endfunction

  function automatic hit_rec_t rec(bit h, logic [FACE_W-1:0] f);
    hit_rec_t r;
    r.hit = h;
    r.face = f;
    return r;
  endfunction

  task automatic send(ray_box_t rb, bit known, hit_rec_t res);
    hit_rec_t p;
    p = box_hit(rb);
    if (known && p != res)
      $display("ERROR: predictor disagrees with directed row %0d/%0d vs %0d/%0d",
               p.hit, p.face, res.hit, res.face);
    if (known && p != res) mismatches++;
    in_tdata <= pack_ray_box(rb);
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    hits_pending.push_back(known ? res : p);
  endtask

  task automatic gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) out_tready <= ($urandom_range(0, 7) != 0) || (cycles[9:8] == 2'b01);
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      hit_rec_t want;
      n_results <= n_results + 1;
      if (hits_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", out_tdata);
      end else begin
        want = hits_pending.pop_front();
        n_hits <= n_hits + want.hit;
        if (out_tdata[0] !== want.hit || out_tdata[3:1] !== want.face ||
            out_tdata[7:4] !== 4'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: hit exp %0d got %0d, face exp %0d got %0d",
                     want.hit, out_tdata[0], want.face, out_tdata[3:1]);
        end
      end
    end
  end

  initial begin
    int burst;
    // Unit box (Q19.12) at [1,2], origin 0: diagonal ray enters on left.
    dir_rows.push_back('{mk(4096, 8192, 0, 16384, 16384, 16384), 1, rec(1, FACE_LEFT)});
    dir_rows.push_back('{mk(4096, 8192, 0, -16384, -16384, -16384), 1, rec(0, FACE_RIGHT)});
    // Zero direction, origin inside / outside the slabs; then rays along one axis.
    dir_rows.push_back('{mk(-4096, 4096, 0, 0, 0, 0), 1, rec(1, FACE_LEFT)});
    dir_rows.push_back('{mk(4096, 8192, 0, 0, 0, 0), 1, rec(0, FACE_LEFT)});
    dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0), 1, rec(1, FACE_LEFT)});
    dir_rows.push_back('{mk(-4096, 4096, 0, 16384, 0, 0), 1, rec(1, FACE_LEFT)});
    dir_rows.push_back('{mk(-4096, 4096, 0, 0, 16384, 0), 1, rec(1, FACE_BOTTOM)});
    dir_rows.push_back('{mk(-4096, 4096, 0, 0, 0, 16384), 1, rec(1, FACE_FRONT)});
    dir_rows.push_back('{mk(-4096, 4096, 0, 0, 0, -16384), 1, rec(1, FACE_BACK)});
    dir_rows.push_back('{mk(-4096, 4096, 0, -16384, 0, 0), 1, rec(1, FACE_RIGHT)});
    dir_rows.push_back('{mk(-4096, 4096, 0, 0, -16384, 0), 1, rec(1, FACE_TOP)});
    // Field extremes: saturation, tiny directions, inverted box.
    dir_rows.push_back('{mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1, 1, 1), 0, '0});
    dir_rows.push_back('{mk(32'h80000000, 32'h7FFFFFFF, 32'h80000000, -1, 1, -1), 0, '0});
    dir_rows.push_back('{mk(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16384, -16384, 1), 0, '0});
    dir_rows.push_back('{mk(8192, 4096, 0, 16384, 16384, 16384), 0, '0});
    dir_rows.push_back('{mk(32'hFFFFFFFF, 1, 0, 16'h7FFF, 16'h8000, 16'hFFFF), 0, '0});
    dir_rows.push_back('{mk(32'h55555555, 32'hAAAAAAAA, 32'h12345678, 16'h5555, 16'hAAAA, 3), 0, '0});
    dir_rows.push_back('{mk(100, 200, 150, 16384, -5, 7), 0, '0});

    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send(dir_rows[i].rb, dir_rows[i].known, dir_rows[i].res);
      gap();
    end
    burst = 0;
    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND / 2) begin
        // drain the pipe completely once
        in_tvalid <= 0;
        while (hits_pending.size() != 0) @(posedge clk);
      end
      send(rand_ray_box(), 0, '0);
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap();
      end else burst--;
    end
    in_tvalid <= 0;
    while (hits_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d ray/box transfers checked, %0d hits, directed faces and zero-dir slabs",
             n_results, n_hits);
    if (mismatches == 0) $display("simulation ok");
    else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end
endmodule
